[hw/rtl/bsm_pkg.sv]
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared word types and the radius limit constant for the bounding sphere merge block.
// ----------------------------------------------------------------------------
package bsm_pkg;

  localparam logic [30:0] RADIUS_MAX = 31'h7FFF_FFFF;

  // input word: two spheres, centers signed Q15.16, radii unsigned Q15.16
  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic        [30:0] first_radius;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic        [30:0] second_radius;
  } bsm_in_t;

  // result word
  typedef struct packed {
    logic signed [31:0] merged_x;
    logic signed [31:0] merged_y;
    logic signed [31:0] merged_z;
    logic        [30:0] merged_radius;
    logic               spheres_overlap;
  } bsm_out_t;

  // classified pair handed from the front part to the back part
  typedef struct packed {
    logic [65:0]       d2;
    logic              enclosed;
    logic              overlap;
    logic              pick_first;
    logic [2:0][31:0]  c1;
    logic [2:0][31:0]  c2;
    logic [2:0]        neg;
    logic [2:0][31:0]  aoff;
    logic [30:0]       r1;
    logic [30:0]       r2;
  } bsm_cls_t;

endpackage

[hw/rtl/bounding_sphere_merge.sv]
// ----------------------------------------------------------------------------
// bounding_sphere_merge
// Smallest sphere enclosing two spheres, with an overlap flag.
// ----------------------------------------------------------------------------
// Takes one sphere pair per clock cycle while in_full is low and returns one
// result word per pair, in order. A pair passes the front (offsets, squares,
// the enclosure and overlap tests), a QUEUE_DEPTH-word queue, and then the
// back pipeline: an entry register, 33 square-root stages (one root bit each),
// two radius stages, 31 divide stages (one fraction bit each), a multiply
// stage and the result register. The length of the root and divide chains
// sets the latency; throughput stays at one pair per cycle while pop keeps up.
// When the result register is not popped the back pipeline holds, the queue
// fills, and then full rises.
module bounding_sphere_merge import bsm_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  bsm_in_t  in_data,
  output logic     out_empty,
  input  logic     out_pop,
  output bsm_out_t out_data
);

  logic     cls_vld;
  bsm_cls_t cls_data;
  logic     q_full, q_empty, q_push, q_pop;
  bsm_cls_t q_data;

  assign q_push = cls_vld && !q_full;

  bsm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .cls_vld  (cls_vld),
    .cls_data (cls_data),
    .cls_full (q_full)
  );

  bsm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (cls_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  bsm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("queue read while empty");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> out_empty) else $error("result present right after reset");

  a_full_holds_front: assert property (@(posedge clk) disable iff (!rst_n)
    (cls_vld && q_full) |-> in_full) else $error("front advanced into a full queue");

endmodule

[hw/rtl/bsm_front.sv]
// ----------------------------------------------------------------------------
// bsm_front
// Three-stage front: center offsets, exact squares, squared distance and the
// enclosure and overlap tests.
// ----------------------------------------------------------------------------
module bsm_front import bsm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  bsm_in_t  in_data,
  output logic     cls_vld,
  output bsm_cls_t cls_data,
  input  logic     cls_full
);

  typedef struct packed {
    logic              pick_first;
    logic [2:0][31:0]  c1;
    logic [2:0][31:0]  c2;
    logic [2:0]        neg;
    logic [2:0][31:0]  aoff;
    logic [30:0]       r1;
    logic [30:0]       r2;
    logic [31:0]       rsum;
    logic [30:0]       rdiff;
  } f1_t;

  typedef struct packed {
    f1_t              base;
    logic [2:0][63:0] sq;
    logic [63:0]      rsum2;
    logic [61:0]      rdiff2;
  } f2_t;

  logic     adv;
  logic     v1_r, v2_r, v3_r;
  f1_t      f1_r, f1_nxt;
  f2_t      f2_r, f2_nxt;
  bsm_cls_t f3_r, f3_nxt;

  assign adv      = !v3_r || !cls_full;
  assign in_full  = !adv;
  assign cls_vld  = v3_r;
  assign cls_data = f3_r;

  always_comb begin
    logic [2:0][32:0] off;
    logic [2:0][31:0] c1v, c2v;
    c1v = {in_data.first_z, in_data.first_y, in_data.first_x};
    c2v = {in_data.second_z, in_data.second_y, in_data.second_x};
    f1_nxt.c1 = c1v;
    f1_nxt.c2 = c2v;
    for (int a = 0; a < 3; a++) begin
      off[a] = {c2v[a][31], c2v[a]} - {c1v[a][31], c1v[a]};
      f1_nxt.neg[a]  = off[a][32];
      f1_nxt.aoff[a] = off[a][32] ? 32'(-off[a]) : off[a][31:0];
    end
    f1_nxt.r1         = in_data.first_radius;
    f1_nxt.r2         = in_data.second_radius;
    f1_nxt.rsum       = {1'b0, in_data.first_radius} + {1'b0, in_data.second_radius};
    f1_nxt.pick_first = in_data.first_radius > in_data.second_radius;
    f1_nxt.rdiff      = f1_nxt.pick_first ? in_data.first_radius - in_data.second_radius
                                          : in_data.second_radius - in_data.first_radius;
  end

  always_comb begin
    f2_nxt.base = f1_r;
    for (int a = 0; a < 3; a++) begin
      f2_nxt.sq[a] = {32'b0, f1_r.aoff[a]} * {32'b0, f1_r.aoff[a]};
    end
    f2_nxt.rsum2  = {32'b0, f1_r.rsum} * {32'b0, f1_r.rsum};
    f2_nxt.rdiff2 = {31'b0, f1_r.rdiff} * {31'b0, f1_r.rdiff};
  end

  always_comb begin
    logic [65:0] d2;
    d2 = {2'b0, f2_r.sq[0]} + {2'b0, f2_r.sq[1]} + {2'b0, f2_r.sq[2]};
    f3_nxt.d2         = d2;
    f3_nxt.enclosed   = d2 <= {4'b0, f2_r.rdiff2};
    f3_nxt.overlap    = !({2'b0, f2_r.rsum2} <= d2);
    f3_nxt.pick_first = f2_r.base.pick_first;
    f3_nxt.c1         = f2_r.base.c1;
    f3_nxt.c2         = f2_r.base.c2;
    f3_nxt.neg        = f2_r.base.neg;
    f3_nxt.aoff       = f2_r.base.aoff;
    f3_nxt.r1         = f2_r.base.r1;
    f3_nxt.r2         = f2_r.base.r2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_push;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_r <= f1_nxt;
      f2_r <= f2_nxt;
      f3_r <= f3_nxt;
    end
  end

endmodule

[hw/rtl/bsm_queue.sv]
// ----------------------------------------------------------------------------
// bsm_queue
// Small first-in first-out buffer for classified pairs between front and back.
// ----------------------------------------------------------------------------
module bsm_queue import bsm_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  bsm_cls_t push_data,
  output logic     full,
  input  logic     pop,
  output bsm_cls_t pop_data,
  output logic     empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULLC = CW'(DEPTH);

  bsm_cls_t      mem_r [DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r;

  assign full     = cnt_r == FULLC;
  assign empty    = cnt_r == '0;
  assign pop_data = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == LAST) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == LAST) ? '0 : rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

[hw/rtl/bsm_back.sv]
// ----------------------------------------------------------------------------
// bsm_back
// Back pipeline: bit-per-stage square root, merged radius, bit-per-stage
// fraction divide, center move multiply and result select.
// ----------------------------------------------------------------------------
module bsm_back import bsm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_empty,
  input  bsm_cls_t q_data,
  output logic     q_pop,
  output logic     out_empty,
  input  logic     out_pop,
  output bsm_out_t out_data
);

  localparam int SQ_N  = 33;          // root bits
  localparam int DIV_N = 31;          // fraction bits after the integer bit
  localparam int S_RT  = SQ_N;        // stage holding the root
  localparam int S_RAD = S_RT + 1;    // merged radius and k
  localparam int S_DI  = S_RAD + 1;   // divide initialized
  localparam int S_DV  = S_DI + DIV_N;
  localparam int S_MV  = S_DV + 1;    // moves multiplied
  localparam int NST   = S_MV + 1;

  typedef struct packed {
    bsm_cls_t         item;
    logic [34:0]      rem;
    logic [32:0]      root;
    logic [32:0]      big_r;
    logic [31:0]      quo;
    logic [2:0][31:0] mv;
  } stage_t;

  logic     adv;
  logic     vld_r [NST];
  stage_t   st_r  [NST];
  stage_t   st_nxt[NST];
  logic     out_vld_r;
  bsm_out_t out_r, out_nxt;

  assign adv       = !out_vld_r || out_pop;
  assign q_pop     = adv && !q_empty;
  assign out_empty = !out_vld_r;
  assign out_data  = out_r;

  always_comb begin
    st_nxt[0]       = '0;
    st_nxt[0].item  = q_data;
  end

  for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
    localparam int PB = 2 * (SQ_N - 1 - i);
    always_comb begin
      logic [36:0] acc;
      logic [36:0] trial;
      acc   = {st_r[i].rem, st_r[i].item.d2[PB+1:PB]};
      trial = {2'b0, st_r[i].root, 2'b01};
      st_nxt[i+1] = st_r[i];
      if (acc >= trial) begin
        st_nxt[i+1].rem  = 35'(acc - trial);
        st_nxt[i+1].root = {st_r[i].root[31:0], 1'b1};
      end else begin
        st_nxt[i+1].rem  = acc[34:0];
        st_nxt[i+1].root = {st_r[i].root[31:0], 1'b0};
      end
    end
  end

  // merged radius and distance share k = R - r1
  always_comb begin
    logic [33:0] sum;
    logic [33:0] k;
    sum = {1'b0, st_r[S_RT].root} + {3'b0, st_r[S_RT].item.r1}
        + {3'b0, st_r[S_RT].item.r2};
    st_nxt[S_RAD]       = st_r[S_RT];
    st_nxt[S_RAD].big_r = sum[33:1];
    k = {1'b0, sum[33:1]} - {3'b0, st_r[S_RT].item.r1};
    st_nxt[S_RAD].rem   = {1'b0, k};
  end

  // clamp k to d and take the integer bit of k/d
  always_comb begin
    logic [32:0] kc;
    logic        q0;
    kc = (st_r[S_RAD].rem[33:0] > {1'b0, st_r[S_RAD].root}) ? st_r[S_RAD].root
                                                           : st_r[S_RAD].rem[32:0];
    q0 = (st_r[S_RAD].root != '0) && (kc == st_r[S_RAD].root);
    st_nxt[S_DI]     = st_r[S_RAD];
    st_nxt[S_DI].rem = q0 ? '0 : {2'b0, kc};
    st_nxt[S_DI].quo = {31'b0, q0};
  end

  for (genvar j = 0; j < DIV_N; j++) begin : g_div
    always_comb begin
      logic [33:0] r2;
      r2 = {st_r[S_DI+j].rem[32:0], 1'b0};
      st_nxt[S_DI+j+1] = st_r[S_DI+j];
      if (r2 >= {1'b0, st_r[S_DI+j].root}) begin
        st_nxt[S_DI+j+1].rem = {1'b0, r2 - {1'b0, st_r[S_DI+j].root}};
        st_nxt[S_DI+j+1].quo = {st_r[S_DI+j].quo[30:0], 1'b1};
      end else begin
        st_nxt[S_DI+j+1].rem = {1'b0, r2};
        st_nxt[S_DI+j+1].quo = {st_r[S_DI+j].quo[30:0], 1'b0};
      end
    end
  end

  always_comb begin
    logic [63:0] prod;
    st_nxt[S_MV] = st_r[S_DV];
    for (int a = 0; a < 3; a++) begin
      prod = {32'b0, st_r[S_DV].item.aoff[a]} * {32'b0, st_r[S_DV].quo};
      st_nxt[S_MV].mv[a] = prod[62:31];
    end
  end

  always_comb begin
    logic [2:0][31:0] ctr;
    logic [30:0]      rad;
    stage_t           s;
    s   = st_r[S_MV];
    rad = (s.big_r > {2'b0, RADIUS_MAX}) ? RADIUS_MAX : s.big_r[30:0];
    if (s.item.enclosed) begin
      ctr = s.item.pick_first ? s.item.c1 : s.item.c2;
      rad = s.item.pick_first ? s.item.r1 : s.item.r2;
    end else if (s.root == '0) begin
      ctr = s.item.c1;
    end else begin
      for (int a = 0; a < 3; a++) begin
        ctr[a] = s.item.neg[a] ? s.item.c1[a] - s.mv[a] : s.item.c1[a] + s.mv[a];
      end
    end
    out_nxt.merged_x        = ctr[0];
    out_nxt.merged_y        = ctr[1];
    out_nxt.merged_z        = ctr[2];
    out_nxt.merged_radius   = rad;
    out_nxt.spheres_overlap = s.item.overlap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NST; s++) begin
        vld_r[s] <= 1'b0;
      end
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= q_pop;
      for (int s = 1; s < NST; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
      out_vld_r <= vld_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < NST; s++) begin
        st_r[s] <= st_nxt[s];
      end
      out_r <= out_nxt;
    end
  end

endmodule
